[hdl/sst_pkg.sv]
// Shared constants, types and codes for the sorted set table.
package sst_pkg;

  localparam int DEPTH      = 256;
  localparam int VALUE_BITS = 32;

  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int FUNC_BITS  = 2;
  localparam int DATA_BITS  = 32;
  localparam int INDEX_BITS = 8;
  localparam int CAP_BITS   = 9;
  localparam int COUNT_BITS = 9;

  // Width wide enough to compare the count against capacity and index.
  localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_ERASE    = 2'd1,
    FUNC_CONTAINS = 2'd2,
    FUNC_GET      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_GET_RD,
    S_GET_DATA,
    S_REPLY
  } state_t;

endpackage

[hdl/sst_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module sst_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32,
  parameter int ABITS_P = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ABITS_P-1:0] waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [ABITS_P-1:0] raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sorted_set_table.sv]
// Top level of the sorted set table: sequencer, count and capacity registers, result register.
//
// The block holds a set of distinct values, largest first, in one RAM of DEPTH entries
// with a registered read. A command is taken at a rising edge where start is
// high and busy is low; busy then stays high until the command is finished, and exactly
// one result follows, shown for a single cycle with done high. The receiver cannot hold a
// result off, so it must capture it in the cycle that done is high; a new command may be
// started in that same cycle. Timing is set by the single RAM port pair: insert, erase and
// contains first scan the entries from the top, one read per cycle, until the first entry
// not above the value. An insert then moves each smaller entry down one place and an erase
// moves each later entry up one place, one entry per cycle. Since the scan stops where the
// shift begins, each entry is visited once, save that an insert reads the entry at its
// own place again. A get whose index is below the count reads its entry in S_GET_RD and
// replies from S_GET_DATA; an insert into a full set and a get past the end go straight
// to S_REPLY. The capacity register is written over its own valid/ready channel, which
// is always ready, and should only be changed while no command is in flight. The RAM
// contents are not cleared at reset: only positions below the count are ever read, and
// those are always written first, so the block is usable right after reset.
module sorted_set_table (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [sst_pkg::FUNC_BITS-1:0]  func,
  input  logic [sst_pkg::DATA_BITS-1:0]  value,
  input  logic [sst_pkg::INDEX_BITS-1:0] index,
  // Capacity register write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sst_pkg::CAP_BITS-1:0]   cfg_data,
  // Result channel.
  output logic                         done,
  output logic                         ok,
  output logic [sst_pkg::DATA_BITS-1:0]  item_out,
  output logic [sst_pkg::COUNT_BITS-1:0] count,
  output logic                         is_empty
);

  import sst_pkg::*;

  // Control state.
  state_t                state;
  state_t                state_next;
  logic [CNT_BITS-1:0]   entry_count;
  logic [CNT_BITS-1:0]   entry_count_next;
  logic [CAP_BITS-1:0]   capacity;

  // The command being worked on.
  func_t                 op;
  logic [VALUE_BITS-1:0] val;
  logic [INDEX_BITS-1:0] idx;

  // Scan and shift bookkeeping. pend marks that rd_data holds the entry at pend_addr.
  logic                  pend;
  logic [ADDR_BITS-1:0]  pend_addr;
  logic [CNT_BITS-1:0]   scan_ptr;
  logic [ADDR_BITS-1:0]  sh_ptr;
  logic [CNT_BITS-1:0]   sh_left;
  logic [CNT_BITS-1:0]   pos;
  logic                  reply_ok;

  // RAM ports.
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [VALUE_BITS-1:0] rd_data;

  // Sequencer outputs.
  logic                  finish;
  logic                  fin_ok;
  logic [DATA_BITS-1:0]  fin_item;
  logic                  cnt_inc;
  logic                  cnt_dec;

  // Decodes.
  logic                  accept;
  func_t                 func_in;
  logic [CMP_BITS-1:0]   cap_eff;
  logic                  set_full;
  logic                  idx_valid;
  logic                  hit;
  logic                  scan_done;
  logic                  found;
  logic [CNT_BITS-1:0]   pos_found;
  logic                  sh_end;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign func_in   = func_t'(func);

  // The effective capacity never exceeds the built depth.
  assign cap_eff   = (CMP_BITS'(capacity) > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH)
                                                              : CMP_BITS'(capacity);
  assign set_full  = CMP_BITS'(entry_count) >= cap_eff;
  assign idx_valid = CMP_BITS'(idx) < CMP_BITS'(entry_count);

  // The scan stops at the first entry that is not above the value. Because the entries
  // are in descending order, the value is present only if that entry equals it, and an
  // insert belongs at exactly that place.
  assign hit       = pend && (rd_data <= val);
  assign scan_done = hit || (scan_ptr == entry_count);
  assign found     = hit && (rd_data == val);
  assign pos_found = hit ? CNT_BITS'(pend_addr) : entry_count;

  // A shift is over once every read has been issued and its write-back made.
  assign sh_end    = (sh_left == '0) && !pend;

  assign entry_count_next = cnt_inc ? entry_count + CNT_BITS'(1) :
                            cnt_dec ? entry_count - CNT_BITS'(1) : entry_count;

  sst_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (VALUE_BITS),
    .ABITS_P (ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_in)
            FUNC_INSERT:   state_next = set_full ? S_REPLY : S_SCAN;
            FUNC_ERASE:    state_next = S_SCAN;
            FUNC_CONTAINS: state_next = S_SCAN;
            FUNC_GET: begin
              state_next = (CMP_BITS'(index) < CMP_BITS'(entry_count)) ? S_GET_RD : S_REPLY;
            end
            default:       state_next = S_REPLY;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          case (op)
            FUNC_INSERT: state_next = found ? S_REPLY : S_SHIFT_DN;
            FUNC_ERASE:  state_next = found ? S_SHIFT_UP : S_REPLY;
            default:     state_next = S_REPLY;
          endcase
        end
      end
      S_SHIFT_DN: begin
        if (sh_end) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT_UP: begin
        if (sh_end) begin
          state_next = S_IDLE;
        end
      end
      S_GET_RD:   state_next = S_GET_DATA;
      S_GET_DATA: state_next = S_IDLE;
      S_REPLY:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: RAM accesses, result and count update.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val;
    finish    = 1'b0;
    fin_ok    = 1'b0;
    fin_item  = '0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_SCAN: begin
        if (!scan_done) begin
          mem_re    = 1'b1;
          mem_raddr = scan_ptr[ADDR_BITS-1:0];
        end
      end
      S_SHIFT_DN: begin
        // Read downward from the last entry and write each one place lower.
        if (sh_left != '0) begin
          mem_re    = 1'b1;
          mem_raddr = sh_ptr;
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + ADDR_BITS'(1);
          mem_wdata = rd_data;
        end else if (sh_end) begin
          mem_we    = 1'b1;
          mem_waddr = pos[ADDR_BITS-1:0];
          mem_wdata = val;
          finish    = 1'b1;
          fin_ok    = 1'b1;
          cnt_inc   = 1'b1;
        end
      end
      S_SHIFT_UP: begin
        // Read upward past the erased entry and write each one place higher.
        if (sh_left != '0) begin
          mem_re    = 1'b1;
          mem_raddr = sh_ptr;
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr - ADDR_BITS'(1);
          mem_wdata = rd_data;
        end else if (sh_end) begin
          finish    = 1'b1;
          fin_ok    = 1'b1;
          cnt_dec   = 1'b1;
        end
      end
      S_GET_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_BITS'(idx);
      end
      S_GET_DATA: begin
        finish    = 1'b1;
        fin_ok    = 1'b1;
        fin_item  = DATA_BITS'(rd_data);
      end
      S_REPLY: begin
        finish    = 1'b1;
        fin_ok    = reply_ok;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      done        <= finish;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      case (state)
        S_SCAN:     pend <= !scan_done;
        S_SHIFT_DN: pend <= (sh_left != '0);
        S_SHIFT_UP: pend <= (sh_left != '0);
        default:    pend <= 1'b0;
      endcase
    end
  end

  // Command, pointer and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= func_in;
      val      <= VALUE_BITS'(value);
      idx      <= index;
      scan_ptr <= '0;
      // Only the early replies use this: a full insert or a get past the end.
      reply_ok <= 1'b0;
    end
    if (state == S_SCAN) begin
      if (!scan_done) begin
        pend_addr <= scan_ptr[ADDR_BITS-1:0];
        scan_ptr  <= scan_ptr + CNT_BITS'(1);
      end else begin
        pos      <= pos_found;
        // An insert only replies from here when the value is already present.
        reply_ok <= (op == FUNC_INSERT) ? 1'b0 : found;
        if (op == FUNC_INSERT) begin
          sh_left <= entry_count - pos_found;
          sh_ptr  <= ADDR_BITS'(entry_count - CNT_BITS'(1));
        end else begin
          sh_left <= entry_count - pos_found - CNT_BITS'(1);
          sh_ptr  <= ADDR_BITS'(pos_found + CNT_BITS'(1));
        end
      end
    end
    if ((state == S_SHIFT_DN || state == S_SHIFT_UP) && (sh_left != '0)) begin
      pend_addr <= sh_ptr;
      sh_left   <= sh_left - CNT_BITS'(1);
      sh_ptr    <= (state == S_SHIFT_DN) ? sh_ptr - ADDR_BITS'(1) : sh_ptr + ADDR_BITS'(1);
    end
    if (finish) begin
      ok       <= fin_ok;
      item_out <= fin_item;
      count    <= COUNT_BITS'(entry_count_next);
      is_empty <= (entry_count_next == '0);
    end
  end

`ifndef SYNTH
  // Every finished command leaves the sequencer idle with its result showing.
  a_fell_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // The RAM is written only while entries are being moved or placed.
  a_write_in_shift: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SHIFT_DN || state == S_SHIFT_UP))
    else $error("RAM written outside a shift");

  // The count moves only together with a result.
  a_count_with_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && entry_count != $past(entry_count)) |-> done)
    else $error("count changed without a result");

  // The reported count matches the stored count.
  a_count_port: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == COUNT_BITS'(entry_count)))
    else $error("reported count differs from stored count");

  // A get is only issued for an index below the count.
  a_get_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_GET_RD) |-> idx_valid)
    else $error("get read past the end of the set");
`endif

endmodule

[tb/sorted_set_table_tb.sv]
// Self-checking testbench for the sorted set table: directed table, random phases, predictor.
`timescale 1ns / 100ps

module sorted_set_table_tb;
  import sst_pkg::*;

  // One result as the block reports it: success flag, entry read, count and empty flag.
  typedef struct packed {
    logic                  ok;
    logic [DATA_BITS-1:0]  item;
    logic [COUNT_BITS-1:0] cnt;
    logic                  empty;
  } set_result_t;

  // One row of the directed table. A row may first change the capacity, and where its
  // result can be read off at a glance the row carries that result typed in.
  typedef struct packed {
    logic                  wr_cap;
    logic [CAP_BITS-1:0]   cap;
    func_t                 op;
    logic [DATA_BITS-1:0]  v;
    logic [INDEX_BITS-1:0] idx;
    logic                  typed;
    set_result_t           want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_BITS-1:0]  func = '0;
  logic [DATA_BITS-1:0]  value = '0;
  logic [INDEX_BITS-1:0] index = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_BITS-1:0]   cfg_data = '0;
  logic                  done;
  logic                  ok;
  logic [DATA_BITS-1:0]  item_out;
  logic [COUNT_BITS-1:0] count;
  logic                  is_empty;

  // Predictor state: the set in descending order, its size and the capacity register.
  logic [DATA_BITS-1:0] set_vals [DEPTH];
  int                   set_size = 0;
  logic [CAP_BITS-1:0]  cap_reg = CAP_RESET;

  // Results predicted at acceptance and not yet seen on the result ports, oldest first.
  set_result_t pending_results [$];

  logic [DATA_BITS-1:0] corner_vals [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                            32'h8000_0000, 32'h7FFF_FFFF};

  int fail_count  = 0;
  int op_tally [4] = '{0, 0, 0, 0};
  int ok_tally    = 0;
  int peak_size   = 0;
  int cap_writes  = 0;
  int burst_left  = 0;

  script_row_t script [$];

  sorted_set_table uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .func     (func),
    .value    (value),
    .index    (index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .ok       (ok),
    .item_out (item_out),
    .count    (count),
    .is_empty (is_empty)
  );

  always #2 clk = ~clk;

  // Applies one command to the predicted set and returns the result it must produce.
  // Insert fails on a duplicate or when the size has reached the smaller of capacity and
  // depth; it places the value ahead of the first smaller entry. Erase closes the gap.
  function automatic set_result_t predict_op(func_t op, logic [DATA_BITS-1:0] v,
                                             logic [INDEX_BITS-1:0] idx);
    set_result_t r;
    int          lim;
    int          pos;
    int          p;
    r   = '0;
    lim = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
    pos = -1;
    for (int k = 0; k < set_size; k++) begin
      if (pos < 0 && set_vals[k] == v) pos = k;
    end
    case (op)
      FUNC_INSERT: begin
        if (set_size < lim && pos < 0) begin
          p = 0;
          while (p < set_size && !(v > set_vals[p])) p++;
          for (int j = set_size; j > p; j--) set_vals[j] = set_vals[j-1];
          set_vals[p] = v;
          set_size++;
          r.ok = 1'b1;
        end
      end
      FUNC_ERASE: begin
        if (pos >= 0) begin
          for (int j = pos; j + 1 < set_size; j++) set_vals[j] = set_vals[j+1];
          set_size--;
          r.ok = 1'b1;
        end
      end
      FUNC_CONTAINS: r.ok = (pos >= 0);
      default: begin
        if (int'(idx) < set_size) begin
          r.ok   = 1'b1;
          r.item = set_vals[idx];
        end
      end
    endcase
    r.cnt   = COUNT_BITS'(set_size);
    r.empty = (set_size == 0);
    if (set_size > peak_size) peak_size = set_size;
    return r;
  endfunction

  function automatic script_row_t step_row(bit wr, int cap, func_t op, logic [31:0] v,
                                           int idx, bit typed, bit w_ok = 0,
                                           logic [31:0] w_item = 0, int w_cnt = 0);
    script_row_t row;
    row.wr_cap     = wr;
    row.cap        = CAP_BITS'(cap);
    row.op         = op;
    row.v          = v;
    row.idx        = INDEX_BITS'(idx);
    row.typed      = typed;
    row.want.ok    = w_ok;
    row.want.item  = w_item;
    row.want.cnt   = COUNT_BITS'(w_cnt);
    row.want.empty = (w_cnt == 0);
    return row;
  endfunction

  // Presents one command and holds it until the block takes it. Start is left high on
  // return, so the caller either presents the next command in the same time step or
  // lowers start for a gap. The expectation is queued at the accepting edge, in order.
  task automatic send_item(func_t op, logic [DATA_BITS-1:0] v, logic [INDEX_BITS-1:0] idx,
                           bit typed, set_result_t want);
    set_result_t got;
    start <= 1'b1;
    func  <= op;
    value <= v;
    index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = predict_op(op, v, idx);
    op_tally[op]++;
    if (got.ok) ok_tally++;
    pending_results.push_back(typed ? want : got);
  endtask

  // Stops sending until every expected result has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity is only written while the block is idle, so callers drain first.
  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = c;
    cap_writes++;
  endtask

  // Sender pacing: bursts of back-to-back commands of random length, separated by random
  // gaps, and now and then a full pause until nothing is outstanding.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      drain();
      burst_left = $urandom_range(0, 30);
    end else begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // One random phase at a given capacity. The percentages weight insert, erase and
  // contains (get takes the rest), and hit_pct is how often the value is taken from the
  // entries already stored, so that erase and contains find something.
  task automatic run_phase(int n, int cap, int ins_pct, int era_pct, int con_pct,
                           int hit_pct);
    func_t                 op;
    logic [DATA_BITS-1:0]  v;
    logic [INDEX_BITS-1:0] idx;
    int                    r;
    drain();
    write_capacity(CAP_BITS'(cap));
    repeat (n) begin
      r  = $urandom_range(0, 99);
      op = (r < ins_pct) ? FUNC_INSERT :
           (r < ins_pct + era_pct) ? FUNC_ERASE :
           (r < ins_pct + era_pct + con_pct) ? FUNC_CONTAINS : FUNC_GET;
      r = $urandom_range(0, 99);
      if (r < hit_pct && set_size > 0) v = set_vals[$urandom_range(0, set_size - 1)];
      else if (r < hit_pct + 15) v = $urandom_range(0, 15);
      else if (r < hit_pct + 22) v = corner_vals[$urandom_range(0, 3)];
      else v = $urandom;
      // Gets mostly aim inside the set; the rest, and all other commands, get any index.
      if (op == FUNC_GET && set_size > 0 && $urandom_range(0, 9) < 7)
        idx = INDEX_BITS'($urandom_range(0, set_size - 1));
      else
        idx = INDEX_BITS'($urandom_range(0, 255));
      send_item(op, v, idx, 1'b0, '0);
      pace();
    end
  endtask

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding: ok=%0d item=%h count=%0d",
               ok, item_out, count);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (ok !== exp_r.ok) begin
          $error("ok mismatch: expected %0d, got %0d", exp_r.ok, ok);
          fail_count++;
        end
        if (item_out !== exp_r.item) begin
          $error("item_out mismatch: expected %h, got %h", exp_r.item, item_out);
          fail_count++;
        end
        if (count !== exp_r.cnt) begin
          $error("count mismatch: expected %0d, got %0d", exp_r.cnt, count);
          fail_count++;
        end
        if (is_empty !== exp_r.empty) begin
          $error("is_empty mismatch: expected %0d, got %0d", exp_r.empty, is_empty);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // Directed table. Rows with typed results cover the empty set after reset, both
    // value extremes, a duplicate insert, gets at and past the end and a zero capacity. The
    // rest go through the predictor: erase at the front and the back, a get and an insert
    // whose unused field is nonzero, an insert into a set full by capacity, and a capacity
    // lowered below the count.
    script.push_back(step_row(0, 0, FUNC_GET,      32'h0,         0,   1, 0, 0, 0));
    script.push_back(step_row(0, 0, FUNC_CONTAINS, 32'h0,         0,   1, 0, 0, 0));
    script.push_back(step_row(0, 0, FUNC_ERASE,    32'h5,         0,   1, 0, 0, 0));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h0,         0,   1, 1, 0, 1));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'hFFFF_FFFF, 0,   1, 1, 0, 2));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h0,         0,   1, 0, 0, 2));
    script.push_back(step_row(0, 0, FUNC_GET,      32'h0,         0,   1, 1, 32'hFFFF_FFFF, 2));
    script.push_back(step_row(0, 0, FUNC_GET,      32'h0,         1,   1, 1, 0, 2));
    script.push_back(step_row(0, 0, FUNC_GET,      32'h0,         2,   1, 0, 0, 2));
    script.push_back(step_row(0, 0, FUNC_GET,      32'hFFFF_FFFF, 255, 1, 0, 0, 2));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h8000_0000, 255, 0));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h7FFF_FFFF, 0,   0));
    script.push_back(step_row(0, 0, FUNC_CONTAINS, 32'h7FFF_FFFF, 0,   0));
    script.push_back(step_row(0, 0, FUNC_GET,      32'hAAAA_AAAA, 1,   0));
    script.push_back(step_row(0, 0, FUNC_ERASE,    32'hFFFF_FFFF, 0,   0));
    script.push_back(step_row(0, 0, FUNC_ERASE,    32'h0,         0,   0));
    script.push_back(step_row(0, 0, FUNC_ERASE,    32'h8000_0000, 0,   0));
    script.push_back(step_row(0, 0, FUNC_CONTAINS, 32'h8000_0000, 0,   0));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h1234_5678, 255, 0));
    script.push_back(step_row(1, 0, FUNC_INSERT,   32'h1,         0,   1, 0, 0, 2));
    script.push_back(step_row(1, 3, FUNC_INSERT,   32'h5,         0,   0));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h6,         0,   0));
    script.push_back(step_row(1, 1, FUNC_ERASE,    32'h5,         0,   0));
    script.push_back(step_row(0, 0, FUNC_INSERT,   32'h9,         0,   0));
    script.push_back(step_row(0, 0, FUNC_CONTAINS, 32'h1234_5678, 0,   0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].wr_cap) begin
        drain();
        write_capacity(script[i].cap);
      end
      send_item(script[i].op, script[i].v, script[i].idx, script[i].typed, script[i].want);
      pace();
    end

    // Fill past the depth with capacity above it, then mix at exactly the depth, drain
    // with a small capacity below the count, and finish with a random capacity.
    run_phase(320, 511, 90, 3, 4, 5);
    run_phase(150, 256, 25, 25, 25, 50);
    run_phase(200, 17, 5, 70, 10, 80);
    run_phase(100, $urandom_range(2, 255), 40, 25, 15, 40);

    drain();
    repeat (32) @(posedge clk);

    $display("Sent %0d commands: %0d insert, %0d erase, %0d contains, %0d get; %0d succeeded.",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3], ok_tally);
    $display("Peak occupancy %0d of %0d entries across %0d capacity settings.",
             peak_size, DEPTH, cap_writes);
    if (fail_count == 0) begin
      $display("** sorted_set_table: PASSED **");
    end else begin
      $display("** sorted_set_table: FAILED **");
    end
    $finish;
  end

  // The slowest correct run is near 800 commands plus gaps, under 1 ms; this allows many
  // times that.
  initial begin
    #12_000_000;
    $display("** sorted_set_table: FAILED **");
    $finish;
  end

endmodule
